// ----- rtl/core/usbapra_pkg.sv -----
// Shared types and constants for the USB audio packet rate adapter.
package usbapra_pkg;

	localparam int RING_SAMPLES = 1024;
	localparam int RING_BITS    = $clog2(RING_SAMPLES);
	localparam int TIMER_BITS   = 20;
	localparam int SPF_BITS     = 9;
	localparam int BYTES_BITS   = 13;
	localparam int OFFSET_BITS  = 11;
	localparam int SAMPLES_BITS = 10;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_BITS     = 20;
	localparam int IN_DATA_BITS  = 40;
	localparam int IN_USER_BITS  = 2;
	localparam int OUT_DATA_BITS = 40;
	localparam int OUT_USER_BITS = 2;
	localparam int STEP_BITS     = $clog2(RING_BITS);

	localparam logic signed [RING_BITS-1:0] RESYNC_LIM = RING_BITS'(50);
	localparam logic signed [RING_BITS-1:0] TRIM_LIM   = RING_BITS'(5);

	localparam logic signed [1:0] ADJ_NONE  = 2'sd0;
	localparam logic signed [1:0] ADJ_LONG  = 2'sd1;
	localparam logic signed [1:0] ADJ_SHORT = -2'sd1;

	localparam logic [CFG_IDX_BITS-1:0] REG_RING_MODULUS = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPF          = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_WIDE         = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_WIDE     = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_NARROW   = 3'd4;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_ELAP  = 7'b0000010,
		ST_WRAP  = 7'b0000100,
		ST_CLAMP = 7'b0001000,
		ST_DIV   = 7'b0010000,
		ST_DEV   = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

endpackage

// ----- rtl/core/usb_audio_packet_rate_adapter.sv -----
// USB audio packet rate adapter: write position estimate, deviation trim, packet sizing.
//
// Channel | Group                      | Word contents
// in      | s_tvalid s_tready s_tdata  | tdata: timer_now, last_wrap_stamp; tuser: codec_on, stream_on
// out     | m_tvalid m_tready m_tdata  | tdata: read_offset, packet_bytes, samples_taken, adjustment
//         |                            | tuser: packet_valid, resynced
// cfg     | cfg_we cfg_index cfg_data  | register write, no read-back
//
// An item passes through ELAP, WRAP and CLAMP to form the elapsed tick count, then
// a restoring divider by the ring modulus yields one quotient bit per cycle in DIV;
// DEV then forms the deviation and EMIT writes the result word. A new item is taken
// only in IDLE. An item with codec_on low is accepted and dropped with no result word.
// The result register lets the next item in while its word is still held;
// the final step waits only if that register is still occupied. Reset is asynchronous.
module usb_audio_packet_rate_adapter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// timer_now [19:0], last_wrap_stamp [39:20]
	input  logic [usbapra_pkg::IN_DATA_BITS-1:0]  s_tdata,
	// codec_on [0], stream_on [1]
	input  logic [usbapra_pkg::IN_USER_BITS-1:0]  s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// read_offset [10:0], packet_bytes [23:11], samples_taken [33:24], adjustment [35:34], zero [39:36]
	output logic [usbapra_pkg::OUT_DATA_BITS-1:0] m_tdata,
	// packet_valid [0], resynced [1]
	output logic [usbapra_pkg::OUT_USER_BITS-1:0] m_tuser,
	input  logic                                cfg_we,
	input  logic [usbapra_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [usbapra_pkg::CFG_BITS-1:0]      cfg_data
);
	import usbapra_pkg::*;

	state_t state_q;

	logic [TIMER_BITS-1:0]   modulus_q;
	logic [SPF_BITS-1:0]     spf_q;
	logic                    wide_q;
	logic [BYTES_BITS-1:0]   max_wide_q;
	logic [BYTES_BITS-1:0]   max_narrow_q;

	logic [TIMER_BITS-1:0]   now_q;
	logic [TIMER_BITS-1:0]   stamp_q;
	logic                    stream_q;
	logic signed [TIMER_BITS+1:0] sum_q;
	logic [TIMER_BITS-1:0]   elapsed_q;
	logic [TIMER_BITS:0]     rem_q;
	logic [RING_BITS-1:0]    quot_q;
	logic [STEP_BITS-1:0]    step_q;
	logic [RING_BITS-1:0]    read_pos_q;
	logic [RING_BITS-1:0]    rp_q;
	logic signed [1:0]       adj_q;
	logic                    resync_q;

	logic [TIMER_BITS-1:0]   modulus;
	logic signed [TIMER_BITS+1:0] wrap_diff;
	logic [TIMER_BITS:0]     rem_dbl;
	logic                    rem_ge;
	logic [RING_BITS-1:0]    expected;
	logic signed [RING_BITS-1:0] dev;
	logic [SAMPLES_BITS-1:0] samples;
	logic [BYTES_BITS-1:0]   bytes_raw;
	logic [BYTES_BITS-1:0]   limit;
	logic [BYTES_BITS-1:0]   bytes;
	logic [OFFSET_BITS-1:0]  offset;
	logic                    out_free;

	assign modulus   = (modulus_q == '0) ? TIMER_BITS'(1) : modulus_q;
	assign wrap_diff = sum_q - $signed({2'b00, modulus});
	assign rem_dbl   = {rem_q[TIMER_BITS-1:0], 1'b0};
	assign rem_ge    = rem_dbl >= {1'b0, modulus};
	assign expected  = {~quot_q[RING_BITS-1], quot_q[RING_BITS-2:0]};
	// (rp + 3/2 ring - expected) mod ring, less half a ring, is rp - expected as signed
	assign dev       = $signed(read_pos_q - expected);

	always_comb begin
		if (spf_q == '0 && adj_q == ADJ_SHORT) begin
			samples = '0;
		end else begin
			samples = SAMPLES_BITS'({1'b0, spf_q}) + {{(SAMPLES_BITS-2){adj_q[1]}}, adj_q};
		end
		if (wide_q) begin
			bytes_raw = {samples, 3'b000};
			limit     = max_wide_q;
			offset    = {rp_q, 1'b0};
		end else begin
			bytes_raw = {1'b0, samples, 2'b00};
			limit     = max_narrow_q;
			offset    = {1'b0, rp_q};
		end
		bytes = (bytes_raw > limit) ? limit : bytes_raw;
	end

	assign out_free = !m_tvalid || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q    <= TIMER_BITS'(531998);
			spf_q        <= SPF_BITS'(48);
			wide_q       <= 1'b0;
			max_wide_q   <= BYTES_BITS'(1544);
			max_narrow_q <= BYTES_BITS'(772);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RING_MODULUS: modulus_q    <= cfg_data;
				REG_SPF:          spf_q        <= cfg_data[SPF_BITS-1:0];
				REG_WIDE:         wide_q       <= cfg_data[0];
				REG_MAX_WIDE:     max_wide_q   <= cfg_data[BYTES_BITS-1:0];
				REG_MAX_NARROW:   max_narrow_q <= cfg_data[BYTES_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			read_pos_q <= '0;
			m_tvalid   <= 1'b0;
			step_q     <= '0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tuser[0]) begin
						state_q <= ST_ELAP;
					end
				end
				ST_ELAP:  state_q <= ST_WRAP;
				ST_WRAP:  state_q <= ST_CLAMP;
				ST_CLAMP: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_BITS'(RING_BITS - 1)) begin
						state_q <= ST_DEV;
					end
				end
				ST_DEV:   state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						read_pos_q <= rp_q + samples[RING_BITS-1:0];
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				now_q    <= s_tdata[TIMER_BITS-1:0];
				stamp_q  <= s_tdata[2*TIMER_BITS-1:TIMER_BITS];
				stream_q <= s_tuser[1];
			end
			ST_ELAP: begin
				sum_q <= $signed({2'b00, now_q}) + $signed({2'b00, modulus})
					- $signed({2'b00, stamp_q});
			end
			ST_WRAP: begin
				if (!wrap_diff[TIMER_BITS+1]) begin
					elapsed_q <= wrap_diff[TIMER_BITS-1:0];
				end else if (sum_q[TIMER_BITS+1]) begin
					elapsed_q <= '0;
				end else begin
					elapsed_q <= sum_q[TIMER_BITS-1:0];
				end
			end
			ST_CLAMP: begin
				rem_q <= (elapsed_q >= modulus) ? {1'b0, modulus - 1'b1} : {1'b0, elapsed_q};
				quot_q <= '0;
			end
			ST_DIV: begin
				rem_q  <= rem_ge ? rem_dbl - {1'b0, modulus} : rem_dbl;
				quot_q <= {quot_q[RING_BITS-2:0], rem_ge};
			end
			ST_DEV: begin
				if (dev < -RESYNC_LIM || dev > RESYNC_LIM) begin
					adj_q    <= ADJ_NONE;
					resync_q <= 1'b1;
					rp_q     <= expected;
				end else begin
					resync_q <= 1'b0;
					rp_q     <= read_pos_q;
					if (dev < -TRIM_LIM) begin
						adj_q <= ADJ_LONG;
					end else if (dev > TRIM_LIM) begin
						adj_q <= ADJ_SHORT;
					end else begin
						adj_q <= ADJ_NONE;
					end
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					m_tdata <= {4'b0000, adj_q, samples,
						stream_q ? bytes : BYTES_BITS'(0),
						stream_q ? offset : OFFSET_BITS'(0)};
					m_tuser <= {resync_q, stream_q};
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/core/usbapra_checker.sv -----
// Port-level checks for the USB audio packet rate adapter, bound to the top level.
module usbapra_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [usbapra_pkg::OUT_DATA_BITS-1:0] m_tdata,
	input logic [usbapra_pkg::OUT_USER_BITS-1:0] m_tuser
);
	import usbapra_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	a_adj_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[35:34] != 2'b10)
		else $error("adjustment out of range");

	a_resync_nominal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[35:34] == 2'b00)
		else $error("resync word carries an adjustment");

	a_stream_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[23:0] == 24'd0)
		else $error("offset or length set with stream off");

	a_samples: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[33:24] <= 10'd512)
		else $error("sample count out of range");

endmodule

bind usb_audio_packet_rate_adapter usbapra_checker u_usbapra_checker (.*);

// ----- tb/tb_usb_audio_packet_rate_adapter.sv -----
// Testbench for the USB audio packet rate adapter: random and directed frames checked against a predictor.
`timescale 1ns / 1ps

module tb_usb_audio_packet_rate_adapter;
	import usbapra_pkg::*;

	localparam int WP_FRAC  = 256;
	localparam int WP_SPAN  = RING_SAMPLES * WP_FRAC;
	localparam int SETTLE   = 40;
	localparam int HOLD_LEN = 400;

	typedef struct {
		bit        packet_valid;
		bit [10:0] read_offset;
		bit [12:0] packet_bytes;
		bit [9:0]  samples_taken;
		bit [1:0]  adjustment;
		bit        resynced;
		bit [3:0]  pad;
	} frame_result_t;

	class packet_scoreboard;
		bit [19:0] ring_mod;
		bit [8:0]  spf;
		bit        wide;
		bit [12:0] max_wide;
		bit [12:0] max_narrow;
		int        read_idx;
		int        errors;
		frame_result_t pending_q[$];

		function new();
			ring_mod   = 20'd531998;
			spf        = 9'd48;
			wide       = 1'b0;
			max_wide   = 13'd1544;
			max_narrow = 13'd772;
			read_idx   = 0;
			errors     = 0;
		endfunction

		function void write_reg(bit [CFG_IDX_BITS-1:0] idx, bit [CFG_BITS-1:0] val);
			case (idx)
				REG_RING_MODULUS: ring_mod = val[19:0];
				REG_SPF:          spf = val[8:0];
				REG_WIDE:         wide = val[0];
				REG_MAX_WIDE:     max_wide = val[12:0];
				REG_MAX_NARROW:   max_narrow = val[12:0];
				default: ;
			endcase
		endfunction

		function longint modulus_eff();
			return (ring_mod == 0) ? 64'sd1 : longint'(ring_mod);
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		function void note_word(bit [IN_DATA_BITS-1:0] data, bit [IN_USER_BITS-1:0] user);
			longint m, e;
			int pos, aim, rp, dev, adj, samples, bytes, limit, offset;
			bit resync;
			frame_result_t r;
			if (!user[0])
				return;
			m = modulus_eff();
			e = longint'(data[19:0]) + m - longint'(data[39:20]);
			if (e >= m)
				e -= m;
			if (e < 0)
				e = 0;
			if (e >= m)
				e = m - 1;
			pos = int'((e * RING_SAMPLES) / m);
			aim = (pos + RING_SAMPLES / 2) % RING_SAMPLES;
			rp  = read_idx;
			dev = (rp + 3 * RING_SAMPLES / 2 - aim) % RING_SAMPLES - RING_SAMPLES / 2;
			adj = 0;
			resync = 1'b0;
			if (dev < -int'(RESYNC_LIM) || dev > int'(RESYNC_LIM)) begin
				rp = aim;
				resync = 1'b1;
			end else if (dev < -int'(TRIM_LIM)) begin
				adj = 1;
			end else if (dev > int'(TRIM_LIM)) begin
				adj = -1;
			end
			samples = (adj < 0 && spf == 0) ? 0 : int'(spf) + adj;
			if (wide) begin
				bytes  = samples * 8;
				limit  = int'(max_wide);
				offset = rp * 2;
			end else begin
				bytes  = samples * 4;
				limit  = int'(max_narrow);
				offset = rp;
			end
			if (bytes > limit)
				bytes = limit;
			r.packet_valid  = user[1];
			r.read_offset   = user[1] ? offset[10:0] : 11'd0;
			r.packet_bytes  = user[1] ? bytes[12:0] : 13'd0;
			r.samples_taken = samples[9:0];
			r.adjustment    = (adj > 0) ? ADJ_LONG : (adj < 0) ? ADJ_SHORT : ADJ_NONE;
			r.resynced      = resync;
			r.pad           = 4'd0;
			read_idx = (rp + samples) % RING_SAMPLES;
			pending_q.push_back(r);
		endfunction

		function void check_field(string name, int want, int got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_word(bit [OUT_DATA_BITS-1:0] data, bit [OUT_USER_BITS-1:0] user);
			frame_result_t r;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result word, tdata %h tuser %h", $time, data, user);
				errors++;
				return;
			end
			r = pending_q.pop_front();
			check_field("packet_valid", r.packet_valid, user[0]);
			check_field("read_offset", r.read_offset, data[10:0]);
			check_field("packet_bytes", r.packet_bytes, data[23:11]);
			check_field("samples_taken", r.samples_taken, data[33:24]);
			check_field("adjustment", int'($signed(r.adjustment)), int'($signed(data[35:34])));
			check_field("resynced", r.resynced, user[1]);
			check_field("tdata padding", r.pad, data[39:36]);
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata;
	logic [IN_USER_BITS-1:0]  s_tuser;
	logic                     m_tvalid;
	logic                     m_tready;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic [OUT_USER_BITS-1:0] m_tuser;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_BITS-1:0]      cfg_data;

	packet_scoreboard sb = new();

	bit tx_calm;
	bit rx_calm;
	bit hold_req;
	int wp_q;
	int drift;

	usb_audio_packet_rate_adapter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int idle_len(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata, m_tuser);
	end

	// sink side: random stalls, plus a long hold-off on request
	initial begin
		int stall;
		int hold_left;
		stall = 0;
		hold_left = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_LEN;
				m_tready <= 1'b0;
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				stall = idle_len(rx_calm);
			end
		end
	end

	task automatic send_item(bit [19:0] tnow, bit [19:0] stamp, bit codec, bit stream);
		int gap;
		s_tdata  <= {stamp, tnow};
		s_tuser  <= {stream, codec};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_word({stamp, tnow}, {stream, codec});
		gap = idle_len(tx_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// frame whose write estimate puts the read index at a chosen deviation
	task automatic send_dev(int dev, bit stream);
		longint m, e, stamp;
		int aim, pos;
		m = sb.modulus_eff();
		aim = (sb.read_idx - dev + 2 * RING_SAMPLES) % RING_SAMPLES;
		pos = (aim + RING_SAMPLES / 2) % RING_SAMPLES;
		e = (longint'(pos) * m + RING_SAMPLES - 1) / RING_SAMPLES;
		if (e >= m)
			e = m - 1;
		stamp = $urandom_range(0, int'(m - 1));
		send_item(20'((stamp + e) % m), 20'(stamp), 1'b1, stream);
	endtask

	// frame from a capture writer running at the nominal rate plus a slow drift
	task automatic send_tracked();
		longint m, e, stamp;
		m = sb.modulus_eff();
		wp_q = (wp_q + int'(sb.spf) * WP_FRAC + drift + WP_SPAN) % WP_SPAN;
		e = (longint'(wp_q) * m) / WP_SPAN + $urandom_range(0, 7);
		if (e >= m)
			e = m - 1;
		stamp = $urandom_range(0, int'(m - 1));
		send_item(20'((stamp + e) % m), 20'(stamp), 1'b1, $urandom_range(0, 19) != 0);
	endtask

	task automatic run_phase(int n_items);
		int done;
		int r;
		longint m;
		done = 0;
		wp_q = $urandom_range(0, WP_SPAN - 1);
		drift = $urandom_range(0, 80) - 40;
		while (done < n_items) begin
			if (done % 50 == 0) begin
				tx_calm = ($urandom_range(0, 4) == 0);
				rx_calm = ($urandom_range(0, 4) == 0);
			end
			m = sb.modulus_eff();
			r = $urandom_range(0, 99);
			if (r < 4) begin
				send_item(20'($urandom), 20'($urandom), 1'b0, 1'($urandom));
				continue;
			end
			if (r < 14) begin
				send_item(20'($urandom), 20'($urandom), 1'b1, 1'($urandom));
			end else if (r < 22) begin
				wp_q = $urandom_range(0, WP_SPAN - 1);
				send_item(20'($urandom_range(0, int'(m - 1))),
					20'($urandom_range(0, int'(m - 1))), 1'b1, 1'($urandom));
			end else if (r < 37) begin
				send_dev($urandom_range(0, 120) - 60, $urandom_range(0, 9) != 0);
			end else begin
				send_tracked();
			end
			done++;
		end
		s_tvalid <= 1'b0;
		tx_calm = 1'b0;
	endtask

	task automatic settle();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(bit [CFG_IDX_BITS-1:0] idx, bit [CFG_BITS-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic set_config(bit [19:0] m, bit [8:0] spf, bit wide, bit [12:0] mw, bit [12:0] mn);
		settle();
		write_reg(REG_RING_MODULUS, CFG_BITS'(m));
		write_reg(REG_SPF, CFG_BITS'(spf));
		write_reg(REG_WIDE, CFG_BITS'(wide));
		write_reg(REG_MAX_WIDE, CFG_BITS'(mw));
		write_reg(REG_MAX_NARROW, CFG_BITS'(mn));
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		tx_calm   = 1'b0;
		rx_calm   = 1'b0;
		hold_req  = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: elapsed-time edges, codec off, stream off, trim and resync bounds
		send_item(20'd0, 20'd0, 1'b1, 1'b1);
		send_item(20'hFFFFF, 20'd0, 1'b1, 1'b1);
		send_item(20'd0, 20'hFFFFF, 1'b1, 1'b1);
		send_item(20'hFFFFF, 20'hFFFFF, 1'b1, 1'b1);
		send_item(20'h5A5A5, 20'hA5A5A, 1'b0, 1'b1);
		send_dev(0, 1'b1);
		send_dev(5, 1'b1);
		send_dev(6, 1'b1);
		send_dev(-5, 1'b1);
		send_dev(-6, 1'b1);
		send_dev(50, 1'b1);
		send_dev(51, 1'b1);
		send_dev(-50, 1'b1);
		send_dev(-51, 1'b1);
		send_dev(-512, 1'b1);
		send_dev(511, 1'b1);
		send_dev(20, 1'b0);
		send_dev(-20, 1'b0);
		run_phase(150);

		set_config(20'd48000, 9'd48, 1'b1, 13'd8191, 13'd0);
		hold_req = 1'b1;
		run_phase(150);

		set_config(20'hFFFFF, 9'd511, 1'b0, 13'd0, 13'd8191);
		run_phase(150);

		set_config(20'd1, 9'd1, 1'b1, 13'd4, 13'd4);
		run_phase(100);

		// zero modulus and zero nominal samples
		set_config(20'd0, 9'd0, 1'b0, 13'd8191, 13'd0);
		run_phase(100);

		set_config(20'd1000, 9'd511, 1'b1, 13'd1544, 13'd772);
		hold_req = 1'b1;
		run_phase(150);

		set_config(20'd531998, 9'd96, 1'b0, 13'd1544, 13'd100);
		run_phase(150);

		set_config(20'($urandom_range(1, 20'hFFFFF)), 9'($urandom_range(1, 511)),
			1'($urandom), 13'($urandom), 13'($urandom));
		run_phase(150);

		settle();
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
